/* sv/cmq_pkg.sv */
// ============================================================================
// cmq_pkg: shared types and constants for the multi-queue time merge
// Field widths of event words and the controller state encoding.
// ============================================================================
`default_nettype none
package cmq_pkg;
  localparam int IdW    = 32;
  localparam int FlagW  = 16;
  localparam int TimeW  = 48;
  localparam int PayW   = 64;
  localparam int EntryW = FlagW + TimeW + PayW;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_QRD   = 8'b0000_0010,
    ST_QWR   = 8'b0000_0100,
    ST_PRD   = 8'b0000_1000,
    ST_PCMP  = 8'b0001_0000,
    ST_PRD2  = 8'b0010_0000,
    ST_POUT  = 8'b0100_0000,
    ST_HOLD  = 8'b1000_0000
  } state_t;
endpackage
`default_nettype wire

/* sv/cmq_entry_ram.sv */
// ============================================================================
// cmq_entry_ram: event entry store
// One write port, one registered read port; flags, time and payload per word.
// ============================================================================
`default_nettype none
module cmq_entry_ram
  import cmq_pkg::*;
#(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AddrW-1:0]  waddr,
  input  wire logic [EntryW-1:0] wdata,
  input  wire logic [AddrW-1:0]  raddr,
  output logic      [EntryW-1:0] rdata
);
  logic [EntryW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/coalescing_multi_queue_time_merge_top.sv */
// ============================================================================
// coalescing_multi_queue_time_merge_top: timestamp ordered multi-queue merge
// Per-stream FIFOs in a shared entry RAM, tail coalescing, oldest-head pop.
// ============================================================================
// Queue word: slot search, tail read (QRD), write (QWR), then ready again.
// Pop word: each slot head is read from the entry RAM in turn (PRD) and
//   compared (PCMP), then the winner is read again (PRD2) and output (POUT).
//   The result is held until taken, then ready again the next cycle.
// One word at a time; the single read port of the entry RAM sets the rate.
// Reset (rst, sync, high) clears slot state and the sticky drop flag; the
// entry RAM is not cleared; data read from unwritten positions is never used.
`default_nettype none
module coalescing_multi_queue_time_merge_top
  import cmq_pkg::*;
#(
  parameter int STREAMS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // tdata: stream_id[31:0], event_flags[47:32], event_time[95:48], payload[159:96]
  input  wire logic [159:0] s_tdata,
  // tuser: action
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tdata: found[0], out_stream_id[32:1], out_flags[48:33], out_time[96:49],
  //        out_payload[160:97], overflow[161], zero fill to 167
  output logic      [167:0] m_tdata
);
  localparam int SW    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = SW + QW;
  localparam int DEPTH = STREAMS * (1 << QW);

  state_t state;

  // slot table (small, fixed-index registers)
  logic [STREAMS-1:0] used;
  logic [IdW-1:0]     sid  [STREAMS];
  logic [QW-1:0]      head [STREAMS];
  logic [CW-1:0]      cnt  [STREAMS];
  logic               dropped;

  // latched input word
  logic [IdW-1:0]   in_id;
  logic [FlagW-1:0] in_flags;
  logic [TimeW-1:0] in_time;
  logic [PayW-1:0]  in_pay;

  // RAM
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EntryW-1:0] rdata;

  cmq_entry_ram #(.Depth(DEPTH), .AddrW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({in_pay, in_time, in_flags}),
    .raddr(raddr), .rdata(rdata)
  );

  // slot search for queue word
  logic          hit, has_free;
  logic [SW-1:0] hit_s, free_s;
  always_comb begin
    hit = 1'b0; has_free = 1'b0; hit_s = '0; free_s = '0;
    for (int s = STREAMS - 1; s >= 0; s--) begin
      if (used[s] && sid[s] == in_id) begin
        hit = 1'b1; hit_s = SW'(s);
      end
      if (!used[s]) begin
        has_free = 1'b1; free_s = SW'(s);
      end
    end
  end

  logic          q_hit;
  logic [SW-1:0] q_slot;
  logic [SW-1:0] scan;
  logic          scan_ok;   // address of scan issued last cycle was a live slot
  logic [SW-1:0] scan_prev;
  logic          best_ok;
  logic [SW-1:0] best;
  logic [TimeW-1:0] best_time;
  logic          ovf_l;

  logic [QW-1:0] tail_pos;
  assign tail_pos = head[q_slot] + QW'(cnt[q_slot] - CW'(1));

  wire [TimeW-1:0] r_time = rdata[FlagW +: TimeW];

  // tail read back in QWR carries the same flags: overwrite the tail
  logic q_coal;
  assign q_coal = (cnt[q_slot] != '0) && (rdata[FlagW-1:0] == in_flags);

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    raddr = '0;
    unique case (state)
      ST_QRD:  raddr = {q_slot, tail_pos};
      ST_PRD,
      ST_PCMP: raddr = {scan, head[scan]};
      ST_PRD2: raddr = {best, head[best]};
      default: raddr = '0;
    endcase
  end

  // entry write at the end of QWR: coalesce, append or first entry
  always_comb begin
    we    = 1'b0;
    waddr = {q_slot, tail_pos};
    if (state == ST_QWR) begin
      if (q_hit) begin
        if (q_coal) begin
          we = 1'b1;
        end else if (cnt[q_slot] < CW'(QUEUE_DEPTH)) begin
          we    = 1'b1;
          waddr = {q_slot, tail_pos + QW'(1)};
        end
      end else if (!used[q_slot]) begin
        we    = 1'b1;
        waddr = {q_slot, QW'(0)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
      for (int s = 0; s < STREAMS; s++) begin
        head[s] <= '0; cnt[s] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          {in_pay, in_time, in_flags, in_id} <= s_tdata;
          state <= s_tuser ? ST_PRD : ST_QRD;
          scan  <= '0;
          best_ok <= 1'b0;
        end
        ST_QRD: begin
          // q_slot set below from search; tail read issued
          state <= ST_QWR;
        end
        ST_QWR: begin
          state <= ST_IDLE;
          if (q_hit) begin
            if (!q_coal) begin
              if (cnt[q_slot] >= CW'(QUEUE_DEPTH)) begin
                dropped <= 1'b1;
              end else begin
                cnt[q_slot] <= cnt[q_slot] + CW'(1);
              end
            end
          end else if (used[q_slot]) begin
            dropped <= 1'b1;   // no free slot
          end else begin
            used[q_slot] <= 1'b1; sid[q_slot] <= in_id;
            head[q_slot] <= '0; cnt[q_slot] <= CW'(1);
          end
        end
        ST_PRD: begin
          scan_prev <= scan; scan_ok <= used[scan];
          scan <= scan + SW'(1);
          state <= ST_PCMP;
        end
        ST_PCMP: begin
          if (scan_ok && (!best_ok || r_time < best_time ||
              (r_time == best_time && sid[scan_prev] < sid[best]))) begin
            best_ok <= 1'b1; best <= scan_prev; best_time <= r_time;
          end
          if (32'(scan_prev) == STREAMS - 1) begin
            state <= ST_PRD2;
          end else begin
            state <= ST_PRD;
          end
        end
        ST_PRD2: begin
          ovf_l   <= dropped;
          dropped <= 1'b0;
          state   <= ST_POUT;
        end
        ST_POUT: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {6'b0, ovf_l, best_ok ? rdata : EntryW'(0),
                       best_ok ? sid[best] : IdW'(0), best_ok};
          if (best_ok) begin
            cnt[best] <= cnt[best] - CW'(1);
            if (cnt[best] == CW'(1)) begin
              used[best] <= 1'b0; head[best] <= '0;
            end else begin
              head[best] <= head[best] + QW'(1);
            end
          end
          state <= ST_HOLD;
        end
        ST_HOLD: if (m_tready) begin
          m_tvalid <= 1'b0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // combinational slot selection held stable during QRD/QWR
  always_comb begin
    q_slot = hit ? hit_s : (has_free ? free_s : '0);
  end
  assign q_hit = hit;

  // assertions
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accepting while result pending");
  a_ovf_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRD2) |=> !dropped) else $error("sticky not cleared");
endmodule
`default_nettype wire

/* tb/sv/coalescing_multi_queue_time_merge_checker.sv */
// ============================================================================
// coalescing_multi_queue_time_merge_checker: pop result predictor and compare
// Watches both stream channels, keeps its own model of the per-stream FIFOs,
// predicts each pop result and compares accepted result words field by field.
// ============================================================================
`default_nettype none
module coalescing_multi_queue_time_merge_checker #(
  parameter int STREAMS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [159:0] s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [167:0] m_tdata,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_QUEUE = 1'b0;

  typedef struct packed {
    logic        found;
    logic [31:0] id;
    logic [15:0] flags;
    logic [47:0] tstamp;
    logic [63:0] payload;
    logic        overflow;
  } pop_result_t;

  logic        used    [STREAMS];
  logic [31:0] owner   [STREAMS];
  int          head    [STREAMS];
  int          count   [STREAMS];
  logic [15:0] q_flags [STREAMS][QUEUE_DEPTH];
  logic [47:0] q_time  [STREAMS][QUEUE_DEPTH];
  logic [63:0] q_pay   [STREAMS][QUEUE_DEPTH];
  logic        dropped;
  pop_result_t expected_pops[$];

  task automatic enqueue_event(logic [31:0] id, logic [15:0] fl, logic [47:0] ts,
                               logic [63:0] pl);
    int hit, free_s, tail;
    hit = -1;
    free_s = -1;
    for (int s = 0; s < STREAMS; s++) begin
      if (used[s] && owner[s] == id && hit < 0) hit = s;
      if (!used[s] && free_s < 0) free_s = s;
    end
    if (hit >= 0) begin
      if (count[hit] > 0) begin
        tail = (head[hit] + count[hit] - 1) % QUEUE_DEPTH;
        if (q_flags[hit][tail] == fl) begin
          // same flags on the tail: coalesce in place
          q_time[hit][tail] = ts;
          q_pay[hit][tail]  = pl;
          return;
        end
      end
      if (count[hit] >= QUEUE_DEPTH) begin
        dropped = 1'b1;
        return;
      end
      tail = (head[hit] + count[hit]) % QUEUE_DEPTH;
      q_flags[hit][tail] = fl;
      q_time[hit][tail]  = ts;
      q_pay[hit][tail]   = pl;
      count[hit]++;
    end else if (free_s < 0) begin
      dropped = 1'b1;
    end else begin
      used[free_s]  = 1'b1;
      owner[free_s] = id;
      head[free_s]  = 0;
      count[free_s] = 1;
      q_flags[free_s][0] = fl;
      q_time[free_s][0]  = ts;
      q_pay[free_s][0]   = pl;
    end
  endtask

  function automatic pop_result_t pop_oldest();
    pop_result_t r;
    int best;
    logic [47:0] t;
    r = '0;
    best = -1;
    for (int s = 0; s < STREAMS; s++) begin
      if (!used[s] || count[s] == 0) continue;
      t = q_time[s][head[s]];
      // ties go to the lowest stream id
      if (best < 0 || t < q_time[best][head[best]] ||
          (t == q_time[best][head[best]] && owner[s] < owner[best]))
        best = s;
    end
    r.overflow = dropped;
    dropped = 1'b0;
    if (best >= 0) begin
      r.found   = 1'b1;
      r.id      = owner[best];
      r.flags   = q_flags[best][head[best]];
      r.tstamp  = q_time[best][head[best]];
      r.payload = q_pay[best][head[best]];
      head[best] = (head[best] + 1) % QUEUE_DEPTH;
      count[best]--;
      if (count[best] == 0) begin
        used[best] = 1'b0;
        head[best] = 0;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
    if (errors < 10)
      $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    pop_result_t e;
    if (rst) begin
      for (int s = 0; s < STREAMS; s++) begin
        used[s] = 1'b0;
        head[s] = 0;
        count[s] = 0;
      end
      dropped = 1'b0;
      expected_pops.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pops.size() == 0) begin
          report("unexpected result word", '0, m_tdata[63:0]);
        end else begin
          e = expected_pops[0];
          expected_pops.delete(0);
          if (m_tdata[0] !== e.found)
            report("found", 64'(e.found), 64'(m_tdata[0]));
          if (m_tdata[32:1] !== e.id)
            report("stream id", 64'(e.id), 64'(m_tdata[32:1]));
          if (m_tdata[48:33] !== e.flags)
            report("flags", 64'(e.flags), 64'(m_tdata[48:33]));
          if (m_tdata[96:49] !== e.tstamp)
            report("time", 64'(e.tstamp), 64'(m_tdata[96:49]));
          if (m_tdata[160:97] !== e.payload)
            report("payload", e.payload, m_tdata[160:97]);
          if (m_tdata[161] !== e.overflow)
            report("overflow", 64'(e.overflow), 64'(m_tdata[161]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_QUEUE)
          enqueue_event(s_tdata[31:0], s_tdata[47:32], s_tdata[95:48], s_tdata[159:96]);
        else
          expected_pops.insert(expected_pops.size(), pop_oldest());
      end
    end
    pending = expected_pops.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule
`default_nettype wire

/* tb/sv/coalescing_multi_queue_time_merge_top_tb.sv */
// ============================================================================
// coalescing_multi_queue_time_merge_top_tb: stimulus and verdict
// Drives queue and pop words through three idling phases and a long output
// stall; the checker module predicts and compares every pop result.
// ============================================================================
`default_nettype none
module coalescing_multi_queue_time_merge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_QUEUE = 1'b0;
  localparam logic ACT_POP   = 1'b1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;   // id, flags, time, payload from the lowest bit up
  logic         s_tuser = 1'b0; // action
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;        // found, id, flags, time, payload, overflow
  int           errors, pending;

  int send_idle_pct = 18;
  int recv_idle_pct = 54;
  logic hold_off = 1'b0;  // long receiver stall, counted in its own process

  // small id pool so slots get reused and fill up; a few wild ids besides
  logic [31:0] id_pool[10] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h10,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h55, 32'hAAAA_AAAA};

  coalescing_multi_queue_time_merge_top dut (.*);

  coalescing_multi_queue_time_merge_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .errors, .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall, or a forced long stall while hold_off is set
  always @(posedge clk) begin
    m_tready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // long stall early in the first random phase while the sender keeps going
  initial begin
    @(negedge rst);
    repeat (800) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one word; gaps before it follow the sender idle rate
  task automatic send_word(logic act, logic [31:0] id, logic [15:0] fl,
                           logic [47:0] ts, logic [63:0] pl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {pl, ts, fl, id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random();
    logic [31:0] id;
    logic [15:0] fl;
    logic [47:0] ts;
    if ($urandom_range(99) < 45) begin
      send_word(ACT_POP, $urandom, 16'($urandom), 48'({$urandom, $urandom}),
                {$urandom, $urandom});
    end else begin
      id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(9)];
      // few distinct flags so coalescing happens often
      fl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2));
      // narrow time range gives ties; sometimes full range
      ts = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : 48'($urandom_range(20));
      send_word(ACT_QUEUE, id, fl, ts, {$urandom, $urandom});
    end
  endtask

  task automatic drain_to_empty();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, extremes, coalescing, full FIFO, slot overflow
    send_word(ACT_POP, '0, '0, '0, '0);
    send_word(ACT_QUEUE, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, '1);
    send_word(ACT_QUEUE, 32'h0, 16'h0, 48'hFFFF_FFFF_FFFF, '0);
    send_word(ACT_QUEUE, 32'h0, 16'h0, 48'h5, 64'h1234);    // coalesces tail
    send_word(ACT_QUEUE, 32'h0, 16'h1, 48'h0, 64'h5);
    send_word(ACT_POP, '1, '1, '1, '1);
    send_word(ACT_POP, '0, '0, '0, '0);
    send_word(ACT_POP, '0, '0, '0, '0);                     // only stream FFFF_FFFF left
    for (int i = 0; i < 17; i++)                            // full FIFO, drop
      send_word(ACT_QUEUE, 32'h9, 16'(i), 48'(i), 64'(i));
    send_word(ACT_QUEUE, 32'h9, 16'd15, 48'h77, 64'h77);    // coalesce when full
    for (int i = 0; i < 8; i++)                             // out of slots
      send_word(ACT_QUEUE, 32'h100 + i, 16'h0, 48'h3, 64'(i));
    send_word(ACT_POP, '0, '0, '0, '0);

    // phases of idling; long output stall during the first
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 18 : 0;
      for (int n = 0; n < 410; n++)
        send_random();
    end
    // flush everything out with pops
    for (int n = 0; n < 140; n++)
      send_word(ACT_POP, '0, '0, '0, '0);
    drain_to_empty();
    repeat (100) @(posedge clk);

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
